// File: design/priority_message_speech_scheduler_assert.svh
// Assertion macros shared by the speech scheduler RTL.
// Needs nothing else; simulation builds get checks, synthesis gets empty bodies.
`ifndef PRIORITY_MESSAGE_SPEECH_SCHEDULER_ASSERT_SVH
`define PRIORITY_MESSAGE_SPEECH_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define PMSS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmss check failed");
// Next-cycle implication, checked out of reset.
`define PMSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmss check failed");
`else
`define PMSS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define PMSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: design/pmss_pkg.sv
// Shared types, widths and codes for the priority message speech scheduler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pmss_pkg;

  // Sizes
  localparam int DEF_QUEUE_DEPTH = 8;
  localparam int NUM_LEVELS      = 4;
  localparam int LVL_IDX_W       = $clog2(NUM_LEVELS);
  localparam int LOW_FLUSH_ABOVE = 3;
  localparam int CMD_Q_DEPTH     = 2;

  // Field widths
  localparam int LEVEL_W   = 3;
  localparam int HANDLE_W  = 16;
  localparam int LENGTH_W  = 10;
  localparam int ELAPSED_W = 20;
  localparam int ENTRY_W   = LENGTH_W + HANDLE_W;
  localparam int UPC_W     = 16;
  localparam int GAP_W     = 24;
  localparam int REMAIN_W  = 28;
  localparam int PAUSE_W   = 25;
  localparam int PEND_W    = 6;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_US_PER_CHAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_GAP   = 2'd1;
  localparam logic [UPC_W-1:0] UPC_RESET = 16'd62500;
  localparam logic [GAP_W-1:0] GAP_RESET = 24'd1000000;

  // Request opcodes
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef enum logic [1:0] {
    STAT_ACCEPTED  = 2'd0,
    STAT_BAD_LEVEL = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_TICK_DONE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_ENQ       = 2'd0,
    CMD_BAD_LEVEL = 2'd1,
    CMD_TICK      = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic                 op;
    logic [LEVEL_W-1:0]   level;
    logic [HANDLE_W-1:0]  msg_handle;
    logic [LENGTH_W-1:0]  msg_length;
    logic [ELAPSED_W-1:0] elapsed_us;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic                started;
    logic [HANDLE_W-1:0] started_handle;
    logic [LEVEL_W-1:0]  started_level;
    logic                speaking;
    logic                paused;
    logic [PEND_W-1:0]   pending_total;
  } out_item_t;

  // Classified request handed from front to back
  typedef struct packed {
    cmd_kind_t            kind;
    logic [LVL_IDX_W-1:0] q;
    logic [HANDLE_W-1:0]  msg_handle;
    logic [LENGTH_W-1:0]  msg_length;
    logic [ELAPSED_W-1:0] elapsed_us;
  } cmd_t;

endpackage

`default_nettype wire

// File: design/pmss_front.sv
// Front end: accepts requests, classifies them and buffers them in a short queue.
// Depends on pmss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmss_front import pmss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  localparam int PTR_W  = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
  localparam int FILL_W = $clog2(CMD_Q_DEPTH + 1);

  cmd_t              q_mem [CMD_Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  cmd_t              cls;
  logic              push;
  logic              pop;

  // Classify the incoming request
  always_comb begin
    cls.q          = '0;
    cls.msg_handle = in_data.msg_handle;
    cls.msg_length = in_data.msg_length;
    cls.elapsed_us = in_data.elapsed_us;
    if (in_data.op == OP_TICK) begin
      cls.kind = CMD_TICK;
    end else if (in_data.level != '0 && in_data.level <= LEVEL_W'(NUM_LEVELS)) begin
      cls.kind = CMD_ENQ;
      cls.q    = LVL_IDX_W'(in_data.level - LEVEL_W'(1));
    end else begin
      cls.kind = CMD_BAD_LEVEL;
    end
  end

  assign in_ready  = (fill_r != FILL_W'(CMD_Q_DEPTH));
  assign push      = in_valid && in_ready;
  assign pop       = cmd_pop && cmd_valid;
  assign cmd_valid = (fill_r != '0);
  assign cmd       = q_mem[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CMD_Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CMD_Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue payload, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

// File: design/pmss_back.sv
// Back end: message store, per-level FIFO pointers, speech/pause timers, config.
// Depends on pmss_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "priority_message_speech_scheduler_assert.svh"

module pmss_back import pmss_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd,
  output logic                  cmd_pop,
  input  logic                  out_free,
  output logic                  res_valid,
  output out_item_t             res,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = SLOT_W + 1;
  localparam int STORE_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  typedef enum logic {S_IDLE, S_POP} bk_state_t;

  bk_state_t            state_r, state_nxt;
  logic [SLOT_W-1:0]    head_r [NUM_LEVELS];
  logic [SLOT_W-1:0]    head_nxt [NUM_LEVELS];
  logic [CNT_W-1:0]     cnt_r [NUM_LEVELS];
  logic [CNT_W-1:0]     cnt_nxt [NUM_LEVELS];
  logic                 ready_r, ready_nxt;
  logic                 speaking_r, speaking_nxt;
  logic                 paused_r, paused_nxt;
  logic [REMAIN_W-1:0]  remain_r, remain_nxt;
  logic [PAUSE_W-1:0]   pause_el_r, pause_el_nxt;
  logic [LVL_IDX_W-1:0] pop_q_r, pop_q_nxt;
  logic [UPC_W-1:0]     upc_r;
  logic [GAP_W-1:0]     gap_r;

  // Message store
  logic [ENTRY_W-1:0]   store_mem [STORE_DEPTH];
  logic [ENTRY_W-1:0]   rd_data_r;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    wr_addr;
  logic                 wr_en;

  // Working signals
  logic                 take;
  logic                 tick_pop;
  logic                 found;
  logic [LVL_IDX_W-1:0] sel_q;
  logic [SUM_W-1:0]     slot_sum;
  logic [SLOT_W-1:0]    wr_slot;
  logic [PAUSE_W:0]     pause_sum;
  logic [ELAPSED_W-1:0] dt;
  logic [ENTRY_W-1:0]   prod;
  logic [CNT_W-1:0]     left_cnt;
  logic [PEND_W-1:0]    pend;
  logic                 cnt_ok;

  assign take    = (state_r == S_IDLE) && cmd_valid && out_free;
  assign cmd_pop = take;
  assign dt      = cmd.elapsed_us;
  assign prod    = ENTRY_W'(rd_data_r[ENTRY_W-1:HANDLE_W] * upc_r);

  // Highest non-empty level
  always_comb begin
    found = 1'b0;
    sel_q = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (cnt_r[i] != '0) begin
        found = 1'b1;
        sel_q = LVL_IDX_W'(i);
      end
    end
  end

  // Tail slot of the addressed level
  always_comb begin
    slot_sum = SUM_W'(head_r[cmd.q]) + SUM_W'(cnt_r[cmd.q]);
    if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
      wr_slot = SLOT_W'(slot_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      wr_slot = SLOT_W'(slot_sum);
    end
  end

  // Next-state logic for one request
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    ready_nxt    = ready_r;
    speaking_nxt = speaking_r;
    paused_nxt   = paused_r;
    remain_nxt   = remain_r;
    pause_el_nxt = pause_el_r;
    pop_q_nxt    = pop_q_r;
    wr_en        = 1'b0;
    wr_addr      = ADDR_W'(cmd.q * QUEUE_DEPTH) + ADDR_W'(wr_slot);
    rd_addr      = ADDR_W'(sel_q * QUEUE_DEPTH) + ADDR_W'(head_r[sel_q]);
    res_valid    = 1'b0;
    res.status         = STAT_TICK_DONE;
    res.started        = 1'b0;
    res.started_handle = '0;
    res.started_level  = '0;
    tick_pop     = 1'b0;
    pause_sum    = '0;
    left_cnt     = cnt_r[sel_q] - CNT_W'(1);

    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          unique case (cmd.kind)
            CMD_ENQ: begin
              res_valid = 1'b1;
              if (cnt_r[cmd.q] >= CNT_W'(QUEUE_DEPTH)) begin
                res.status = STAT_FULL;
              end else begin
                res.status       = STAT_ACCEPTED;
                wr_en            = 1'b1;
                cnt_nxt[cmd.q]   = cnt_r[cmd.q] + CNT_W'(1);
              end
            end
            CMD_TICK: begin
              // Silence gap, saturating timer
              if (paused_r) begin
                pause_sum    = (PAUSE_W + 1)'(pause_el_r) + (PAUSE_W + 1)'(dt);
                pause_el_nxt = pause_sum[PAUSE_W] ? '1 : pause_sum[PAUSE_W-1:0];
                if (pause_el_nxt > PAUSE_W'(gap_r)) begin
                  paused_nxt = 1'b0;
                end
              end
              // Ready message starts speaking
              if (ready_r) begin
                speaking_nxt = 1'b1;
                ready_nxt    = 1'b0;
              end
              if (speaking_nxt) begin
                if (REMAIN_W'(dt) > remain_r) begin
                  remain_nxt   = '0;
                  speaking_nxt = 1'b0;
                  paused_nxt   = 1'b1;
                  pause_el_nxt = '0;
                end else begin
                  remain_nxt = remain_r - REMAIN_W'(dt);
                end
              end else if (!paused_nxt && found) begin
                // Pop the front message; its time is set once the store read lands
                tick_pop          = 1'b1;
                ready_nxt         = 1'b1;
                pop_q_nxt         = sel_q;
                head_nxt[sel_q]   = (head_r[sel_q] == SLOT_W'(QUEUE_DEPTH - 1)) ?
                                    '0 : head_r[sel_q] + SLOT_W'(1);
                cnt_nxt[sel_q]    = left_cnt;
                if (sel_q == '0 && left_cnt > CNT_W'(LOW_FLUSH_ABOVE)) begin
                  cnt_nxt[sel_q] = '0;
                end
                state_nxt = S_POP;
              end
              res_valid = !tick_pop;
            end
            default: begin
              res_valid  = 1'b1;
              res.status = STAT_BAD_LEVEL;
            end
          endcase
        end
      end
      S_POP: begin
        remain_nxt         = REMAIN_W'(prod);
        res_valid          = 1'b1;
        res.started        = 1'b1;
        res.started_handle = rd_data_r[HANDLE_W-1:0];
        res.started_level  = LEVEL_W'(pop_q_r) + LEVEL_W'(1);
        state_nxt          = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Flags and pending count after the request
    pend = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      pend = pend + PEND_W'(cnt_nxt[i]);
    end
    res.speaking      = speaking_nxt;
    res.paused        = paused_nxt;
    res.pending_total = pend;
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '{default: '0};
      cnt_r      <= '{default: '0};
      ready_r    <= 1'b0;
      speaking_r <= 1'b0;
      paused_r   <= 1'b0;
      remain_r   <= '0;
      pause_el_r <= '0;
      pop_q_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      cnt_r      <= cnt_nxt;
      ready_r    <= ready_nxt;
      speaking_r <= speaking_nxt;
      paused_r   <= paused_nxt;
      remain_r   <= remain_nxt;
      pause_el_r <= pause_el_nxt;
      pop_q_r    <= pop_q_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UPC_RESET;
      gap_r <= GAP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_US_PER_CHAR: upc_r <= cfg_data[UPC_W-1:0];
        REG_PAUSE_GAP:   gap_r <= cfg_data[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= {cmd.msg_length, cmd.msg_handle};
    end
    rd_data_r <= store_mem[rd_addr];
  end

  // Every level count stays within the queue depth
  always_comb begin
    cnt_ok = 1'b1;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (cnt_r[i] > CNT_W'(QUEUE_DEPTH)) begin
        cnt_ok = 1'b0;
      end
    end
  end

  // Checks
  `PMSS_ASSERT_IMPLY(a_res_slot_free, clk, rst_n, res_valid, out_free)
  `PMSS_ASSERT_IMPLY(a_ready_not_speaking, clk, rst_n, 1'b1, !(ready_r && speaking_r))
  `PMSS_ASSERT_IMPLY(a_pop_reports_start, clk, rst_n, state_r == S_POP, res_valid && res.started)
  `PMSS_ASSERT_NEXT(a_pop_sets_ready, clk, rst_n, take && tick_pop, state_r == S_POP && ready_r)
  `PMSS_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, cnt_ok)

endmodule

`default_nettype wire

// File: design/priority_message_speech_scheduler.sv
// Top level of the priority message speech scheduler: front, back and result register.
// Depends on pmss_pkg, pmss_front and pmss_back.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_data   (in_item_t)
//   out_     output     out_valid / out_ready  out_data  (out_item_t)
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Enqueue requests and ticks that start nothing are answered from S_IDLE; a tick
// that starts a message also passes S_POP (store read, then length times us_per_char).
// The front takes a request every cycle while its two-entry queue has room.
// Reset is synchronous; queues come up empty, timers and flags clear.
// The back end stalls while the result register holds an untaken result, and in S_POP.
`timescale 1ns / 1ps
`default_nettype none

module priority_message_speech_scheduler import pmss_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;
  logic      out_free;
  logic      res_valid;
  out_item_t res;
  logic      out_valid_r;
  out_item_t out_data_r;

  pmss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  pmss_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Config writes are always accepted and land immediately; unused indexes are ignored
  assign cfg_ready = 1'b1;

  // Result register
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire
